// ===== sv/ubx_frame_parser_core_defines.svh =====
// Assertion macros shared by the frame parser RTL.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef UBX_FRAME_PARSER_CORE_DEFINES_SVH
`define UBX_FRAME_PARSER_CORE_DEFINES_SVH

// Same-cycle implication.
`define FRMP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FRMP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/frmp_pkg.sv =====
// Package for the frame parser: phase, status and kind codes, register
// indexes and the config/result structs. No dependencies.
package frmp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK_A    = 4'd7,
        PH_CK_B    = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        ST_GOOD_WANTED = 2'd0,
        ST_GOOD_OTHER  = 2'd1,
        ST_BAD_SUM     = 2'd2
    } status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    localparam logic [1:0] CFG_WANTED_CLASS  = 2'd0;
    localparam logic [1:0] CFG_WANTED_ID     = 2'd1;
    localparam logic [1:0] CFG_WANTED_LENGTH = 2'd2;

    localparam logic [7:0]  RST_WANTED_CLASS  = 8'h01;
    localparam logic [7:0]  RST_WANTED_ID     = 8'h07;
    localparam logic [15:0] RST_WANTED_LENGTH = 16'd92;

    typedef struct packed {
        logic [7:0]  wanted_class;
        logic [7:0]  wanted_id;
        logic [15:0] wanted_length;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_offset;
        logic [7:0]  frame_class;
        logic [7:0]  frame_id;
        status_t     status;
        logic        last;
    } res_t;

endpackage

// ===== sv/ubx_frame_parser_core.sv =====
// Frame parser top: input byte register, parser step, result register.
// A byte passes from the input byte register through the parser step into the result register on m_*.
// Throughput: one byte per cycle while the result register is not stalled by m_tready.
// A stalled result register holds the input register; ready drops only then.
// Reset (aresetn low, synchronous) empties both registers, returns to sync hunt
// and loads the wanted message registers with class 0x01, id 0x07, length 92.
module ubx_frame_parser_core
    import frmp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] payload_byte, [23:8] byte_offset,
                                   // [31:24] frame_class, [39:32] frame_id,
                                   // [41:40] status, [47:42] zero
    output logic        m_tuser,   // [0] kind
    output logic        m_tlast,   // last
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

`include "ubx_frame_parser_core_defines.svh"

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    res_t       out_res_reg;

    logic       proc_go;
    logic       step_valid;
    res_t       step_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wanted_class  <= RST_WANTED_CLASS;
            cfg_reg.wanted_id     <= RST_WANTED_ID;
            cfg_reg.wanted_length <= RST_WANTED_LENGTH;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_WANTED_CLASS:  cfg_reg.wanted_class  <= cfg_data[7:0];
                CFG_WANTED_ID:     cfg_reg.wanted_id     <= cfg_data[7:0];
                CFG_WANTED_LENGTH: cfg_reg.wanted_length <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // step the parser when a byte is held and the result slot can take it
    assign proc_go  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    frmp_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (proc_go),
        .rx_byte   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (step_valid),
        .res       (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_go) begin
            out_valid_reg <= step_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_go && step_valid) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, out_res_reg.status, out_res_reg.frame_id,
                       out_res_reg.frame_class, out_res_reg.byte_offset,
                       out_res_reg.payload_byte};
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_res_reg.last;

    `FRMP_ASSERT_NOW(a_payload_fields, m_tvalid && (m_tuser == KIND_PAYLOAD),
        !m_tlast && (m_tdata[41:40] == ST_GOOD_WANTED), "payload item with status or last")
    `FRMP_ASSERT_NOW(a_status_fields, m_tvalid && (m_tuser == KIND_STATUS),
        m_tlast && (m_tdata[23:0] == 24'd0), "status item without last or with payload")
    `FRMP_ASSERT_NOW(a_status_code, m_tvalid, m_tdata[41:40] != 2'd3,
        "unused status code on result")
    `FRMP_ASSERT_NEXT(a_input_hold, in_valid_reg && out_valid_reg && !m_tready,
        in_valid_reg && $stable(in_byte_reg), "held byte lost while result stalled")

endmodule

// ===== sv/frmp_step.sv =====
// Frame parser state: phase sequencer, Fletcher sums and header capture.
// Advances one byte per enabled cycle. Depends on frmp_pkg.
module frmp_step
    import frmp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    output logic       res_valid,
    output res_t       res
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  held_class_reg, held_class_next;
    logic [7:0]  held_id_reg, held_id_next;
    logic [15:0] held_length_reg, held_length_next;
    logic [15:0] byte_count_reg, byte_count_next;
    logic [7:0]  first_check_reg, first_check_next;

    logic [7:0]  sum_a_add;
    logic [15:0] count_inc;
    logic [15:0] length_full;
    logic        wanted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HUNT;
            sum_a_reg       <= '0;
            sum_b_reg       <= '0;
            held_class_reg  <= '0;
            held_id_reg     <= '0;
            held_length_reg <= '0;
            byte_count_reg  <= '0;
            first_check_reg <= '0;
        end else if (step_en) begin
            phase_reg       <= phase_next;
            sum_a_reg       <= sum_a_next;
            sum_b_reg       <= sum_b_next;
            held_class_reg  <= held_class_next;
            held_id_reg     <= held_id_next;
            held_length_reg <= held_length_next;
            byte_count_reg  <= byte_count_next;
            first_check_reg <= first_check_next;
        end
    end

    assign sum_a_add   = sum_a_reg + rx_byte;
    assign count_inc   = byte_count_reg + 16'd1;
    assign length_full = {rx_byte, held_length_reg[7:0]};
    assign wanted      = (held_class_reg == cfg.wanted_class) &&
                         (held_id_reg == cfg.wanted_id) &&
                         (held_length_reg == cfg.wanted_length);

    always_comb begin
        phase_next       = phase_reg;
        sum_a_next       = sum_a_reg;
        sum_b_next       = sum_b_reg;
        held_class_next  = held_class_reg;
        held_id_next     = held_id_reg;
        held_length_next = held_length_reg;
        byte_count_next  = byte_count_reg;
        first_check_next = first_check_reg;

        res_valid        = 1'b0;
        res.kind         = KIND_PAYLOAD;
        res.payload_byte = '0;
        res.byte_offset  = '0;
        res.frame_class  = held_class_reg;
        res.frame_id     = held_id_reg;
        res.status       = ST_GOOD_WANTED;
        res.last         = 1'b0;

        unique case (phase_reg)
            PH_SYNC2: begin
                if (rx_byte == SYNC_SECOND) begin
                    phase_next = PH_CLASS;
                end else if (rx_byte != SYNC_FIRST) begin
                    phase_next = PH_HUNT;
                end
            end
            PH_CLASS: begin
                // sums restart at the class byte
                sum_a_next      = rx_byte;
                sum_b_next      = rx_byte;
                held_class_next = rx_byte;
                phase_next      = PH_ID;
            end
            PH_ID: begin
                sum_a_next   = sum_a_add;
                sum_b_next   = sum_b_reg + sum_a_add;
                held_id_next = rx_byte;
                phase_next   = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                sum_a_next       = sum_a_add;
                sum_b_next       = sum_b_reg + sum_a_add;
                held_length_next = {8'h00, rx_byte};
                phase_next       = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                sum_a_next       = sum_a_add;
                sum_b_next       = sum_b_reg + sum_a_add;
                held_length_next = length_full;
                byte_count_next  = '0;
                phase_next       = (length_full == 16'd0) ? PH_CK_A : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_reg + sum_a_add;
                if (wanted) begin
                    res_valid        = 1'b1;
                    res.payload_byte = rx_byte;
                    res.byte_offset  = byte_count_reg;
                end
                byte_count_next = count_inc;
                if (count_inc == held_length_reg) begin
                    phase_next = PH_CK_A;
                end
            end
            PH_CK_A: begin
                first_check_next = rx_byte;
                phase_next       = PH_CK_B;
            end
            PH_CK_B: begin
                res_valid = 1'b1;
                res.kind  = KIND_STATUS;
                res.last  = 1'b1;
                if ((first_check_reg == sum_a_reg) && (rx_byte == sum_b_reg)) begin
                    res.status = wanted ? ST_GOOD_WANTED : ST_GOOD_OTHER;
                end else begin
                    res.status = ST_BAD_SUM;
                end
                phase_next = PH_HUNT;
            end
            default: begin
                // hunting, and any unused phase code
                phase_next = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
            end
        endcase
    end

endmodule
